[src/lcb_pkg.sv]
// ----------------------------------------------------------------------------
// lcb_pkg: shared constants for the light cluster binning block
// Grid geometry, field widths, action and register codes.
// ----------------------------------------------------------------------------
package lcb_pkg;

    // Grid geometry (each size a power of two)
    localparam int GRID_X     = 32;
    localparam int GRID_Y     = 8;
    localparam int GRID_Z     = 32;
    localparam int MAX_LIGHTS = 32;
    localparam int MASK_BITS  = 32;
    localparam int SLOTS      = (MAX_LIGHTS < MASK_BITS) ? MAX_LIGHTS : MASK_BITS;

    localparam int X_BITS = $clog2(GRID_X);
    localparam int Y_BITS = $clog2(GRID_Y);
    localparam int Z_BITS = $clog2(GRID_Z);
    localparam int CELLS  = GRID_X * GRID_Y * GRID_Z;
    localparam int MEM_AW = X_BITS + Y_BITS + Z_BITS;

    // Field widths
    localparam int ACT_W   = 2;
    localparam int COORD_W = 32;
    localparam int RAD_W   = 31;
    localparam int ADDR_W  = 13;
    localparam int SLOT_W  = 5;
    localparam int CNT_W   = 6;
    localparam int IN_W    = 144;
    localparam int OUT_W   = 40;
    localparam int CFG_IW  = 3;

    // Datapath widths
    localparam int CW     = 9;       // cell coordinate, holds 0..256
    localparam int PCW    = 10;      // signed centre cell, -1..256
    localparam int P_W    = 33;      // signed centre offset
    localparam int E_W    = 32;      // region extent (positive)
    localparam int DIV_W  = 42;      // signed numerator of cell division
    localparam int PROD_W = CW + E_W;
    localparam int D_W    = PROD_W + 2;
    localparam longint DIST_SAT = 64'h0000_0000_8000_0000;

    // Axis codes
    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ADD   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

    // Register indexes
    localparam logic [CFG_IW-1:0] CFG_MIN_X = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_MIN_Y = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_MIN_Z = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_MAX_X = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_MAX_Y = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_MAX_Z = 3'd5;

    // Register reset values
    localparam logic signed [COORD_W-1:0] RST_MIN_X = -32'sd3276800;
    localparam logic signed [COORD_W-1:0] RST_MIN_Y = -32'sd65536;
    localparam logic signed [COORD_W-1:0] RST_MIN_Z = -32'sd3276800;
    localparam logic signed [COORD_W-1:0] RST_MAX_X = 32'sd3276800;
    localparam logic signed [COORD_W-1:0] RST_MAX_Y = 32'sd2621440;
    localparam logic signed [COORD_W-1:0] RST_MAX_Z = 32'sd3276800;

    typedef logic [CW-1:0] coord_t;

    function automatic logic [3:0] axis_log2(input logic [1:0] ax);
        case (ax)
            AX_X:    axis_log2 = 4'(X_BITS);
            AX_Y:    axis_log2 = 4'(Y_BITS);
            default: axis_log2 = 4'(Z_BITS);
        endcase
    endfunction

    function automatic coord_t axis_size(input logic [1:0] ax);
        case (ax)
            AX_X:    axis_size = CW'(GRID_X);
            AX_Y:    axis_size = CW'(GRID_Y);
            default: axis_size = CW'(GRID_Z);
        endcase
    endfunction

endpackage

[src/light_cluster_binning_top.sv]
// ----------------------------------------------------------------------------
// light_cluster_binning_top: clustered light assignment into bitmask grid
// Bins light spheres into a 3D cluster grid held in one on-chip memory.
// ----------------------------------------------------------------------------
//
//  channel  | direction | beat contents
//  ---------+-----------+--------------------------------------------------
//  s_axis   | in        | action, centre x/y/z, radius, cluster address
//  m_axis   | out       | cluster mask, assigned slot, light accepted
//  cfg      | in        | register index, 32-bit register value
//
//  Add: setup runs nine divisions of a 42-bit numerator in one shared
//  restoring divider, then one read-modify-write of the mask memory per
//  cluster in the box, written back only inside the sphere; then the
//  result is posted.
//  Clear: one memory write per cluster, over all 8192 clusters, then the
//  result is posted.
//  Reset runs the same clearing pass; no beat is taken meanwhile,
//  configuration writes are taken throughout.
//  A finished result waits in the output register while s_tready rises again.
//
module light_cluster_binning_top
    import lcb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // action[1:0], center_x[33:2], center_y[65:34], center_z[97:66],
    // sphere_radius[128:98], cluster_address[141:129], zero pad
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,
    // cluster_mask[31:0], assigned_slot[36:32], light_accepted[37], zero pad
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [31:0]       cfg_data
);

    // Sequencer states
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CLEAR  = 4'd1;
    localparam logic [3:0] ST_PREP   = 4'd2;
    localparam logic [3:0] ST_DLOAD  = 4'd3;
    localparam logic [3:0] ST_DRUN   = 4'd4;
    localparam logic [3:0] ST_DSTORE = 4'd5;
    localparam logic [3:0] ST_WSTART = 4'd6;
    localparam logic [3:0] ST_SQ     = 4'd7;
    localparam logic [3:0] ST_CELL   = 4'd8;
    localparam logic [3:0] ST_RDREQ  = 4'd9;
    localparam logic [3:0] ST_RDDATA = 4'd10;
    localparam logic [3:0] ST_OUT    = 4'd11;

    // Division kinds: centre cell, first cell, end cell
    localparam logic [1:0] DK_PC = 2'd0;
    localparam logic [1:0] DK_LO = 2'd1;
    localparam logic [1:0] DK_HI = 2'd2;

    // ---------------- control registers ----------------
    logic [3:0]          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [MEM_AW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic                clr_emit_reg, clr_emit_next;
    logic                out_valid_reg, out_valid_next;
    logic [1:0]          ax_reg, ax_next;
    logic [1:0]          kind_reg, kind_next;
    logic [5:0]          dcnt_reg, dcnt_next;
    logic [1:0]          sqax_reg, sqax_next;
    logic [1:0]          sqcnt_reg, sqcnt_next;
    logic signed [COORD_W-1:0] min_reg [3];
    logic signed [COORD_W-1:0] min_next [3];
    logic signed [COORD_W-1:0] max_reg [3];
    logic signed [COORD_W-1:0] max_next [3];

    // ---------------- payload registers ----------------
    logic signed [COORD_W-1:0] c_reg [3];
    logic signed [COORD_W-1:0] c_next [3];
    logic [RAD_W-1:0]          r_reg, r_next;
    logic [ADDR_W-1:0]         addr_reg, addr_next;
    logic [MASK_BITS-1:0]      bit_reg, bit_next;
    logic signed [P_W-1:0]     p_reg [3];
    logic signed [P_W-1:0]     p_next [3];
    logic [E_W-1:0]            e_reg [3];
    logic [E_W-1:0]            e_next [3];
    logic [61:0]               r2_reg, r2_next;
    logic signed [PCW-1:0]     pc_reg [3];
    logic signed [PCW-1:0]     pc_next [3];
    coord_t                    lo_reg [3];
    coord_t                    lo_next [3];
    coord_t                    hi_reg [3];
    coord_t                    hi_next [3];
    coord_t                    cur_reg [3];
    coord_t                    cur_next [3];
    logic [DIV_W-1:0]          dq_reg, dq_next;
    logic [E_W-1:0]            dr_reg, dr_next;
    logic                      dneg_reg, dneg_next;
    logic [PROD_W-1:0]         prod_reg, prod_next;
    logic                      zero_reg, zero_next;
    logic [31:0]               dmag_reg, dmag_next;
    logic [63:0]               sq_reg, sq_next;
    logic [63:0]               sz_reg, sz_next;
    logic [63:0]               syz_reg, syz_next;
    logic [63:0]               sum_reg, sum_next;
    logic [MASK_BITS-1:0]      res_mask_reg, res_mask_next;
    logic [SLOT_W-1:0]         res_slot_reg, res_slot_next;
    logic                      res_acc_reg, res_acc_next;
    logic [MASK_BITS-1:0]      out_mask_reg, out_mask_next;
    logic [SLOT_W-1:0]         out_slot_reg, out_slot_next;
    logic                      out_acc_reg, out_acc_next;

    // ---------------- memory port ----------------
    logic                 mem_we;
    logic [MEM_AW-1:0]    mem_waddr;
    logic [MASK_BITS-1:0] mem_wdata;
    logic [MEM_AW-1:0]    mem_raddr;
    logic [MASK_BITS-1:0] mem_rdata;

    lcb_ram #(
        .WIDTH (MASK_BITS),
        .DEPTH (CELLS)
    ) u_mask_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // ---------------- handshakes ----------------
    logic in_beat;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_beat   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {2'b00, out_acc_reg, out_slot_reg, out_mask_reg};

    // ---------------- distance datapath ----------------
    // Per-axis squared distance from the centre to the nearer cell face:
    // product k*e, then plane offset with saturation, then square.
    coord_t                c_cur;
    logic signed [PCW-1:0] pc_cur;
    logic                  after_pc;
    coord_t                k_val;
    logic [PROD_W-1:0]     prod_calc;
    logic [PROD_W-1:0]     plane;
    logic signed [D_W-1:0] d_calc;
    logic [D_W-1:0]        d_abs;
    logic [31:0]           dmag_calc;
    logic [63:0]           sq_calc;
    logic [MEM_AW-1:0]     cell_addr;

    assign c_cur     = cur_reg[sqax_reg];
    assign pc_cur    = pc_reg[sqax_reg];
    assign after_pc  = $signed({1'b0, c_cur}) > pc_cur;
    assign k_val     = after_pc ? c_cur : c_cur + CW'(1);
    assign prod_calc = PROD_W'(k_val) * PROD_W'(e_reg[sqax_reg]);
    assign plane     = prod_reg >> axis_log2(sqax_reg);
    assign d_calc    = $signed({2'b00, plane}) - D_W'(p_reg[sqax_reg]);
    assign d_abs     = d_calc[D_W-1] ? D_W'(-d_calc) : D_W'(d_calc);
    assign dmag_calc = (d_abs > D_W'(DIST_SAT)) ? 32'h8000_0000 : d_abs[31:0];
    assign sq_calc   = zero_reg ? 64'd0 : 64'(dmag_reg) * 64'(dmag_reg);
    assign cell_addr = {cur_reg[AX_Z][Z_BITS-1:0], cur_reg[AX_Y][Y_BITS-1:0],
                        cur_reg[AX_X][X_BITS-1:0]};

    // ---------------- divider datapath ----------------
    // Restoring division of a signed numerator by the positive extent,
    // one quotient bit per cycle, then floor or ceiling and clamping.
    logic signed [P_W:0]     rad_s;
    logic signed [P_W:0]     base;
    logic signed [DIV_W-1:0] num;
    logic [DIV_W-1:0]        num_mag;
    logic [E_W:0]            div_shift;
    logic                    div_ge;
    logic [E_W:0]            div_sub;
    logic                    inexact;
    logic signed [DIV_W+1:0] q_mag;
    logic signed [DIV_W+1:0] q_res;
    logic signed [DIV_W+1:0] g_s;
    logic signed [PCW-1:0]   q_cl;
    coord_t                  q_pos;

    assign rad_s = $signed({3'b000, r_reg});
    always_comb
    begin
        case (kind_reg)
            DK_LO:   base = (P_W+1)'(p_reg[ax_reg]) - rad_s;
            DK_HI:   base = (P_W+1)'(p_reg[ax_reg]) + rad_s;
            default: base = (P_W+1)'(p_reg[ax_reg]);
        endcase
    end
    assign num       = DIV_W'(base) <<< axis_log2(ax_reg);
    assign num_mag   = num[DIV_W-1] ? DIV_W'(-num) : DIV_W'(num);
    assign div_shift = {dr_reg, dq_reg[DIV_W-1]};
    assign div_ge    = div_shift >= {1'b0, e_reg[ax_reg]};
    assign div_sub   = div_shift - {1'b0, e_reg[ax_reg]};
    assign inexact   = (dr_reg != '0);
    assign q_mag     = $signed({2'b00, dq_reg});
    assign g_s       = (DIV_W+2)'($signed({1'b0, axis_size(ax_reg)}));

    always_comb
    begin
        if (kind_reg == DK_HI)
        begin
            q_res = dneg_reg ? -q_mag : q_mag + (DIV_W+2)'(inexact);
        end
        else
        begin
            q_res = dneg_reg ? -(q_mag + (DIV_W+2)'(inexact)) : q_mag;
        end
        if (q_res < -(DIV_W+2)'(1))
        begin
            q_cl = -PCW'(1);
        end
        else if (q_res > g_s)
        begin
            q_cl = PCW'(g_s);
        end
        else
        begin
            q_cl = PCW'(q_res);
        end
        q_pos = q_cl[PCW-1] ? '0 : q_cl[CW-1:0];
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_emit_next  = clr_emit_reg;
        out_valid_next = out_valid_reg && !m_tready;
        ax_next        = ax_reg;
        kind_next      = kind_reg;
        dcnt_next      = dcnt_reg;
        sqax_next      = sqax_reg;
        sqcnt_next     = sqcnt_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        c_next         = c_reg;
        r_next         = r_reg;
        addr_next      = addr_reg;
        bit_next       = bit_reg;
        p_next         = p_reg;
        e_next         = e_reg;
        r2_next        = r2_reg;
        pc_next        = pc_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        cur_next       = cur_reg;
        dq_next        = dq_reg;
        dr_next        = dr_reg;
        dneg_next      = dneg_reg;
        prod_next      = prod_reg;
        zero_next      = zero_reg;
        dmag_next      = dmag_reg;
        sq_next        = sq_reg;
        sz_next        = sz_reg;
        syz_next       = syz_reg;
        sum_next       = sum_reg;
        res_mask_next  = res_mask_reg;
        res_slot_next  = res_slot_reg;
        res_acc_next   = res_acc_reg;
        out_mask_next  = out_mask_reg;
        out_slot_next  = out_slot_reg;
        out_acc_next   = out_acc_reg;
        mem_we         = 1'b0;
        mem_waddr      = cell_addr;
        mem_wdata      = mem_rdata | bit_reg;
        mem_raddr      = cell_addr;

        // Register writes
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MIN_X: min_next[AX_X] = cfg_data;
                CFG_MIN_Y: min_next[AX_Y] = cfg_data;
                CFG_MIN_Z: min_next[AX_Z] = cfg_data;
                CFG_MAX_X: max_next[AX_X] = cfg_data;
                CFG_MAX_Y: max_next[AX_Y] = cfg_data;
                CFG_MAX_Z: max_next[AX_Z] = cfg_data;
                default:   ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    c_next[AX_X]   = s_tdata[33:2];
                    c_next[AX_Y]   = s_tdata[65:34];
                    c_next[AX_Z]   = s_tdata[97:66];
                    r_next         = s_tdata[128:98];
                    addr_next      = s_tdata[141:129];
                    res_mask_next  = '0;
                    res_slot_next  = '0;
                    res_acc_next   = 1'b0;
                    case (s_tdata[1:0])
                        ACT_CLEAR:
                        begin
                            clr_cnt_next  = '0;
                            clr_emit_next = 1'b1;
                            count_next    = '0;
                            state_next    = ST_CLEAR;
                        end
                        ACT_ADD:
                        begin
                            if (count_reg < CNT_W'(SLOTS))
                            begin
                                res_slot_next = count_reg[SLOT_W-1:0];
                                res_acc_next  = 1'b1;
                                bit_next      = MASK_BITS'(1) << count_reg[SLOT_W-1:0];
                                count_next    = count_reg + CNT_W'(1);
                                state_next    = ST_PREP;
                            end
                            else
                            begin
                                state_next = ST_OUT;
                            end
                        end
                        ACT_READ:
                        begin
                            state_next = ST_RDREQ;
                        end
                        default:
                        begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end

            // Sweep the mask memory, one cluster per cycle
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + MEM_AW'(1);
                if (clr_cnt_reg == MEM_AW'(CELLS - 1))
                begin
                    state_next = clr_emit_reg ? ST_OUT : ST_IDLE;
                end
            end

            // Offsets, extents and squared radius
            ST_PREP:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    p_next[a] = P_W'(c_reg[a]) - P_W'(min_reg[a]);
                    e_next[a] = E_W'(P_W'(max_reg[a]) - P_W'(min_reg[a]));
                end
                r2_next   = 62'(r_reg) * 62'(r_reg);
                ax_next   = AX_X;
                kind_next = DK_PC;
                if ((max_reg[AX_X] <= min_reg[AX_X]) || (max_reg[AX_Y] <= min_reg[AX_Y]) ||
                    (max_reg[AX_Z] <= min_reg[AX_Z]))
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_DLOAD;
                end
            end

            ST_DLOAD:
            begin
                dq_next    = num_mag;
                dr_next    = '0;
                dneg_next  = num[DIV_W-1];
                dcnt_next  = '0;
                state_next = ST_DRUN;
            end

            ST_DRUN:
            begin
                dq_next   = {dq_reg[DIV_W-2:0], div_ge};
                dr_next   = div_ge ? div_sub[E_W-1:0] : div_shift[E_W-1:0];
                dcnt_next = dcnt_reg + 6'd1;
                if (dcnt_reg == 6'(DIV_W - 1))
                begin
                    state_next = ST_DSTORE;
                end
            end

            ST_DSTORE:
            begin
                case (kind_reg)
                    DK_PC:   pc_next[ax_reg] = q_cl;
                    DK_LO:   lo_next[ax_reg] = q_pos;
                    default: hi_next[ax_reg] = q_pos;
                endcase
                if (kind_reg == DK_HI)
                begin
                    kind_next = DK_PC;
                    if (ax_reg == AX_Z)
                    begin
                        state_next = ST_WSTART;
                    end
                    else
                    begin
                        ax_next    = ax_reg + 2'd1;
                        state_next = ST_DLOAD;
                    end
                end
                else
                begin
                    kind_next  = kind_reg + 2'd1;
                    state_next = ST_DLOAD;
                end
            end

            // Drop lights whose clamped box is empty
            ST_WSTART:
            begin
                cur_next   = lo_reg;
                sqax_next  = AX_Z;
                sqcnt_next = '0;
                if ((lo_reg[AX_X] >= hi_reg[AX_X]) || (lo_reg[AX_Y] >= hi_reg[AX_Y]) ||
                    (lo_reg[AX_Z] >= hi_reg[AX_Z]))
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_SQ;
                end
            end

            ST_SQ:
            begin
                sqcnt_next = sqcnt_reg + 2'd1;
                case (sqcnt_reg)
                    2'd0:
                    begin
                        prod_next = prod_calc;
                        zero_next = ($signed({1'b0, c_cur}) == pc_cur);
                    end
                    2'd1:
                    begin
                        dmag_next = dmag_calc;
                    end
                    2'd2:
                    begin
                        sq_next = sq_calc;
                    end
                    default:
                    begin
                        case (sqax_reg)
                            AX_Z:
                            begin
                                sz_next   = sq_reg;
                                sqax_next = AX_Y;
                            end
                            AX_Y:
                            begin
                                syz_next  = sz_reg + sq_reg;
                                sqax_next = AX_X;
                            end
                            default:
                            begin
                                // Issue the mask read for this cluster
                                sum_next   = syz_reg + sq_reg;
                                state_next = ST_CELL;
                            end
                        endcase
                    end
                endcase
            end

            // Modify and write back if the cluster lies within the radius, then step to the next cluster
            ST_CELL:
            begin
                mem_we     = (sum_reg < 64'(r2_reg));
                sqcnt_next = '0;
                if (cur_reg[AX_X] + CW'(1) < hi_reg[AX_X])
                begin
                    cur_next[AX_X] = cur_reg[AX_X] + CW'(1);
                    sqax_next      = AX_X;
                    state_next     = ST_SQ;
                end
                else if (cur_reg[AX_Y] + CW'(1) < hi_reg[AX_Y])
                begin
                    cur_next[AX_X] = lo_reg[AX_X];
                    cur_next[AX_Y] = cur_reg[AX_Y] + CW'(1);
                    sqax_next      = AX_Y;
                    state_next     = ST_SQ;
                end
                else if (cur_reg[AX_Z] + CW'(1) < hi_reg[AX_Z])
                begin
                    cur_next[AX_X] = lo_reg[AX_X];
                    cur_next[AX_Y] = lo_reg[AX_Y];
                    cur_next[AX_Z] = cur_reg[AX_Z] + CW'(1);
                    sqax_next      = AX_Z;
                    state_next     = ST_SQ;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end

            ST_RDREQ:
            begin
                mem_raddr  = MEM_AW'(addr_reg);
                state_next = ST_RDDATA;
            end

            ST_RDDATA:
            begin
                res_mask_next = (32'(addr_reg) < 32'(CELLS)) ? mem_rdata : '0;
                state_next    = ST_OUT;
            end

            // Hold the result until the output register is free
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_mask_next  = res_mask_reg;
                    out_slot_next  = res_slot_reg;
                    out_acc_next   = res_acc_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- control state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            count_reg     <= '0;
            clr_cnt_reg   <= '0;
            clr_emit_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ax_reg        <= AX_X;
            kind_reg      <= DK_PC;
            dcnt_reg      <= '0;
            sqax_reg      <= AX_Z;
            sqcnt_reg     <= '0;
            min_reg[AX_X] <= RST_MIN_X;
            min_reg[AX_Y] <= RST_MIN_Y;
            min_reg[AX_Z] <= RST_MIN_Z;
            max_reg[AX_X] <= RST_MAX_X;
            max_reg[AX_Y] <= RST_MAX_Y;
            max_reg[AX_Z] <= RST_MAX_Z;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_emit_reg  <= clr_emit_next;
            out_valid_reg <= out_valid_next;
            ax_reg        <= ax_next;
            kind_reg      <= kind_next;
            dcnt_reg      <= dcnt_next;
            sqax_reg      <= sqax_next;
            sqcnt_reg     <= sqcnt_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
        end
    end

    // ---------------- payload ----------------
    always_ff @(posedge clk)
    begin
        c_reg        <= c_next;
        r_reg        <= r_next;
        addr_reg     <= addr_next;
        bit_reg      <= bit_next;
        p_reg        <= p_next;
        e_reg        <= e_next;
        r2_reg       <= r2_next;
        pc_reg       <= pc_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        cur_reg      <= cur_next;
        dq_reg       <= dq_next;
        dr_reg       <= dr_next;
        dneg_reg     <= dneg_next;
        prod_reg     <= prod_next;
        zero_reg     <= zero_next;
        dmag_reg     <= dmag_next;
        sq_reg       <= sq_next;
        sz_reg       <= sz_next;
        syz_reg      <= syz_next;
        sum_reg      <= sum_next;
        res_mask_reg <= res_mask_next;
        res_slot_reg <= res_slot_next;
        res_acc_reg  <= res_acc_next;
        out_mask_reg <= out_mask_next;
        out_slot_reg <= out_slot_next;
        out_acc_reg  <= out_acc_next;
    end

endmodule

[src/lcb_ram.sv]
// ----------------------------------------------------------------------------
// lcb_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lcb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/lcb_check.sv]
// ----------------------------------------------------------------------------
// lcb_check: port-level checks for the light cluster binning block
// Watches the stream and configuration ports of the top level.
// ----------------------------------------------------------------------------
module lcb_check
    import lcb_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic [IN_W-1:0]   s_tdata,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [OUT_W-1:0]  m_tdata,
    input logic              cfg_valid,
    input logic              cfg_ready,
    input logic [CFG_IW-1:0] cfg_index,
    input logic [31:0]       cfg_data
);

    // Hold a result beat until it is taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped before it was taken");

    // One item at a time: ready drops after every accepted beat
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat taken while an item is in work");

    // An accepted light never carries a mask
    a_add_no_mask: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[37] |-> (m_tdata[31:0] == '0))
        else $error("accepted light reports a cluster mask");

    // A refused or non-add result carries slot zero
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[37] |-> (m_tdata[36:32] == '0))
        else $error("slot reported without an accepted light");

endmodule

bind light_cluster_binning_top lcb_check u_lcb_check (.*);
